@@ design/tbc_pkg.sv @@
// shared types and constants for the text buffer with cursor
package tbc_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int CMD_W        = 3;
    localparam int CH_W         = 8;
    localparam int ST_W         = 2;
    localparam int CNT_W        = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_FWD   = 3'd0,
        CMD_BACK  = 3'd1,
        CMD_START = 3'd2,
        CMD_END   = 3'd3,
        CMD_INS   = 3'd4,
        CMD_DEL   = 3'd5,
        CMD_DUMP  = 3'd6
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_BOUND = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FWD,
        S_BACK,
        S_INS1,
        S_INS2,
        S_INS3,
        S_DEL1,
        S_DEL2,
        S_DEL3,
        S_DUMP,
        S_DONE
    } t_state;

endpackage

@@ design/tbc_ram.sv @@
// generic single write port ram with registered read
module tbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/text_buffer_with_cursor.sv @@
// editable text buffer with an insertion cursor, kept as a linked list in ram
//
// input channel: i_in_valid / o_in_stall carry one command request with
// i_command and i_ch (the byte, used by insert only). output channel:
// o_out_valid / i_out_stall carry results. every edit or cursor move gives
// one status result with last set; a dump gives one result per text byte,
// cursor_here marking the byte just after the insertion point, or a single
// empty result when the text is empty.
// to start, to end, back at start, refused insert, empty dump and unknown
// commands go straight to the done state; forward, back, insert and delete
// pass through their own states first (delete at end of text leaves after
// its first read). the cell links live in rams with one read and one write
// port each, so an insert or delete reads and writes its links in separate
// states. a dump streams one byte per cycle while the output is not stalled,
// the walk being bound by the registered read of the link ram.
// one command is processed at a time; a new request is taken as soon as the
// block returns to idle, even if its last result still waits in the output
// register. when the receiver stalls the output register holds and the
// sequencer waits. reset (synchronous, active low) empties the text, puts
// the cursor at the start and needs no clearing pass.
module text_buffer_with_cursor #(
    parameter int CAPACITY = tbc_pkg::CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [tbc_pkg::CMD_W-1:0]  i_command,
    input  logic [tbc_pkg::CH_W-1:0]   i_ch,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [tbc_pkg::ST_W-1:0]   o_status,
    output logic [tbc_pkg::CH_W-1:0]   o_data_byte,
    output logic                       o_byte_valid,
    output logic                       o_cursor_here,
    output logic [tbc_pkg::CNT_W-1:0]  o_cursor_index,
    output logic [tbc_pkg::CNT_W-1:0]  o_text_length,
    output logic                       o_last
);

    import tbc_pkg::*;

    localparam int NCELLS = CAPACITY + 1;
    localparam int CW     = $clog2(NCELLS);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CW-1:0]    HEAD    = '0;

    t_state            r_state, n_state;
    logic [CH_W-1:0]   r_ch;
    logic [CW-1:0]     r_cur, n_cur;
    logic [CW-1:0]     r_free, n_free;
    logic [CW-1:0]     r_head_next, n_head_next;
    logic [CW-1:0]     r_head_prev, n_head_prev;
    logic [CW-1:0]     r_nc, n_nc;
    logic [CW-1:0]     r_aux, n_aux;
    logic [CW-1:0]     r_p, n_p;
    logic [CNT_W-1:0]  r_unused, n_unused;
    logic [CNT_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_i, n_i;
    t_status           r_st, n_st;

    logic              r_out_valid;
    logic [ST_W-1:0]   r_o_status, n_o_status;
    logic [CH_W-1:0]   r_o_byte, n_o_byte;
    logic              r_o_bvalid, n_o_bvalid;
    logic              r_o_here, n_o_here;
    logic              r_o_last, n_o_last;
    logic [CNT_W-1:0]  r_o_cidx;
    logic [CNT_W-1:0]  r_o_len;
    logic              out_load;

    // ram ports
    logic              next_we, prev_we, byte_we;
    logic [CW-1:0]     next_waddr, prev_waddr;
    logic [CW-1:0]     next_wdata, prev_wdata;
    logic [CW-1:0]     next_raddr, prev_raddr;
    logic [CW-1:0]     next_q, prev_q;
    logic [CH_W-1:0]   byte_q;

    logic              in_acc;
    logic              out_free;
    logic              ins_full;
    logic              dump_empty;
    logic              dump_last;
    logic [CW-1:0]     next_cur;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign ins_full   = (r_len >= CAP_CNT) || ((r_free == HEAD) && (r_unused >= CAP_CNT));
    assign dump_empty = (r_len == '0) || (r_head_next == HEAD);
    assign dump_last  = ((r_i + CNT_W'(1)) == r_len) || (next_q == HEAD);
    // the head cell's links are held in registers, the rest in ram
    assign next_cur   = (r_cur == HEAD) ? r_head_next : next_q;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_command)
                        CMD_FWD:   n_state = S_FWD;
                        CMD_BACK:  n_state = (r_cur == HEAD) ? S_DONE : S_BACK;
                        CMD_INS:   n_state = ins_full ? S_DONE : S_INS1;
                        CMD_DEL:   n_state = S_DEL1;
                        CMD_DUMP:  n_state = dump_empty ? S_DONE : S_DUMP;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_FWD:  n_state = S_DONE;
            S_BACK: n_state = S_DONE;
            S_INS1: n_state = S_INS2;
            S_INS2: n_state = S_INS3;
            S_INS3: n_state = S_DONE;
            S_DEL1: n_state = (next_cur == HEAD) ? S_DONE : S_DEL2;
            S_DEL2: n_state = S_DEL3;
            S_DEL3: n_state = S_DONE;
            S_DUMP: begin
                if (out_free && dump_last) begin
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_cur       = r_cur;
        n_free      = r_free;
        n_head_next = r_head_next;
        n_head_prev = r_head_prev;
        n_nc        = r_nc;
        n_aux       = r_aux;
        n_p         = r_p;
        n_unused    = r_unused;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_st        = r_st;
        next_we     = 1'b0;
        prev_we     = 1'b0;
        byte_we     = 1'b0;
        next_waddr  = r_cur;
        next_wdata  = r_nc;
        prev_waddr  = r_aux;
        prev_wdata  = r_nc;
        next_raddr  = r_p;
        prev_raddr  = r_cur;
        out_load    = 1'b0;
        n_o_status  = ST_DONE;
        n_o_byte    = '0;
        n_o_bvalid  = 1'b0;
        n_o_here    = 1'b0;
        n_o_last    = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_st = ST_DONE;
                    case (i_command)
                        CMD_FWD: begin
                            next_raddr = r_cur;
                        end
                        CMD_BACK: begin
                            if (r_cur == HEAD) begin
                                n_st = ST_BOUND;
                            end
                        end
                        CMD_START: begin
                            n_cur = HEAD;
                            n_cnt = '0;
                        end
                        CMD_END: begin
                            n_cur = r_head_prev;
                            n_cnt = r_len;
                        end
                        CMD_INS: begin
                            if (ins_full) begin
                                n_st = ST_FULL;
                            end
                            next_raddr = r_free;
                        end
                        CMD_DEL: begin
                            next_raddr = r_cur;
                        end
                        CMD_DUMP: begin
                            n_p        = r_head_next;
                            n_i        = '0;
                            next_raddr = r_head_next;
                        end
                        default: begin
                            n_st = ST_BOUND;
                        end
                    endcase
                end
            end
            S_FWD: begin
                if (next_cur != HEAD) begin
                    n_cur = next_cur;
                    n_cnt = r_cnt + CNT_W'(1);
                end else begin
                    n_st = ST_BOUND;
                end
            end
            S_BACK: begin
                n_cur = prev_q;
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_INS1: begin
                // new cell from the free list, else a never used one
                if (r_free != HEAD) begin
                    n_nc   = r_free;
                    n_free = next_q;
                end else begin
                    n_unused = r_unused + CNT_W'(1);
                    n_nc     = CW'(r_unused + CNT_W'(1));
                end
                next_raddr = r_cur;
            end
            S_INS2: begin
                n_aux      = next_cur;
                next_we    = 1'b1;
                next_waddr = r_nc;
                next_wdata = next_cur;
                prev_we    = 1'b1;
                prev_waddr = r_nc;
                prev_wdata = r_cur;
                byte_we    = 1'b1;
            end
            S_INS3: begin
                if (r_aux == HEAD) begin
                    n_head_prev = r_nc;
                end else begin
                    prev_we    = 1'b1;
                    prev_waddr = r_aux;
                    prev_wdata = r_nc;
                end
                if (r_cur == HEAD) begin
                    n_head_next = r_nc;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = r_cur;
                    next_wdata = r_nc;
                end
                n_cur = r_nc;
                n_cnt = r_cnt + CNT_W'(1);
                n_len = r_len + CNT_W'(1);
            end
            S_DEL1: begin
                if (next_cur == HEAD) begin
                    n_st = ST_BOUND;
                end
                n_aux      = next_cur;
                next_raddr = next_cur;
            end
            S_DEL2: begin
                // unlink: next_q is the cell after the removed one
                if (r_cur == HEAD) begin
                    n_head_next = next_q;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = r_cur;
                    next_wdata = next_q;
                end
                if (next_q == HEAD) begin
                    n_head_prev = r_cur;
                end else begin
                    prev_we    = 1'b1;
                    prev_waddr = next_q;
                    prev_wdata = r_cur;
                end
            end
            S_DEL3: begin
                next_we    = 1'b1;
                next_waddr = r_aux;
                next_wdata = r_free;
                n_free     = r_aux;
                if (r_len != '0) begin
                    n_len = r_len - CNT_W'(1);
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_o_byte   = byte_q;
                    n_o_bvalid = 1'b1;
                    n_o_here   = (r_i == r_cnt);
                    n_o_last   = dump_last;
                    n_p        = next_q;
                    n_i        = r_i + CNT_W'(1);
                    next_raddr = next_q;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_o_status = r_st;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= HEAD;
            r_free      <= HEAD;
            r_head_next <= HEAD;
            r_head_prev <= HEAD;
            r_unused    <= '0;
            r_len       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_free      <= n_free;
            r_head_next <= n_head_next;
            r_head_prev <= n_head_prev;
            r_unused    <= n_unused;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ch <= i_ch;
        end
        r_nc  <= n_nc;
        r_aux <= n_aux;
        r_p   <= n_p;
        r_i   <= n_i;
        r_st  <= n_st;
        if (out_load) begin
            r_o_status <= n_o_status;
            r_o_byte   <= n_o_byte;
            r_o_bvalid <= n_o_bvalid;
            r_o_here   <= n_o_here;
            r_o_last   <= n_o_last;
            r_o_cidx   <= r_cnt;
            r_o_len    <= r_len;
        end
    end

    tbc_ram #(
        .WIDTH (CW),
        .DEPTH (NCELLS)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (next_raddr),
        .o_rdata (next_q)
    );

    tbc_ram #(
        .WIDTH (CW),
        .DEPTH (NCELLS)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (prev_raddr),
        .o_rdata (prev_q)
    );

    // byte store shares the read address of the link walk
    tbc_ram #(
        .WIDTH (CH_W),
        .DEPTH (NCELLS)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (r_nc),
        .i_wdata (r_ch),
        .i_raddr (next_raddr),
        .o_rdata (byte_q)
    );

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_data_byte    = r_o_byte;
    assign o_byte_valid   = r_o_bvalid;
    assign o_cursor_here  = r_o_here;
    assign o_cursor_index = r_o_cidx;
    assign o_text_length  = r_o_len;
    assign o_last         = r_o_last;

endmodule
